[hdl/whlg_pkg.sv]
// Shared types and codes for the load hysteresis governor.
`timescale 1ns / 1ps

package whlg_pkg;

  // Field widths fixed by the item format
  localparam int CountW = 11;
  localparam int CfgW   = 11;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WINDOW     = 2'd0,
    CFG_FAST_THR   = 2'd1,
    CFG_SLOW_THR   = 2'd2,
    CFG_START_FAST = 2'd3
  } whlg_cfg_idx_t;

  // Control from the governor to the busy ring
  typedef struct packed {
    logic issue;   // item accepted with the window enabled: read the oldest bit
    logic commit;  // item in the update stage retires: write its busy bit
    logic clear;   // window rewritten: restart the ring empty
    logic wr_bit;  // busy bit of the retiring item
  } whlg_ring_ctl_t;

endpackage

[hdl/whlg_ring.sv]
// Busy bit ring: memory, write pointer, fill flag and read-after-write forwarding.
`timescale 1ns / 1ps

module whlg_ring #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  whlg_pkg::whlg_ring_ctl_t       ctl,
  input  logic [$clog2(WINDOW_MAX):0]    eff_win,
  output logic                           old_bit
);
  import whlg_pkg::*;

  localparam int PtrW = $clog2(WINDOW_MAX);

  logic            mem [WINDOW_MAX];
  logic [PtrW-1:0] ptr_r, ptr_nxt;
  logic            wrapped_r, wrapped_nxt;
  logic [PtrW-1:0] s1_addr_r;
  logic            s1_seen_r;
  logic            fwd_r;
  logic            fwd_bit_r;
  logic            rdata_r;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   ptr_inc;
  logic            wrap;

  // Current slot; an out-of-window pointer restarts at slot zero
  assign rd_ptr  = ({1'b0, ptr_r} >= eff_win) ? '0 : ptr_r;
  assign ptr_inc = {1'b0, rd_ptr} + 1'b1;
  assign wrap    = ptr_inc >= eff_win;

  // Pointer advance on issue; a clear restarts it at slot zero
  always_comb begin
    ptr_nxt     = ptr_r;
    wrapped_nxt = wrapped_r;
    if (ctl.clear) begin
      ptr_nxt     = '0;
      wrapped_nxt = 1'b0;
    end else if (ctl.issue) begin
      ptr_nxt = wrap ? '0 : ptr_inc[PtrW-1:0];
      if (wrap) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      wrapped_r <= 1'b0;
    end else begin
      ptr_r     <= ptr_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  // Per-item tags for the update stage
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      s1_addr_r <= rd_ptr;
      s1_seen_r <= wrapped_r;
      fwd_r     <= ctl.commit && (s1_addr_r == rd_ptr);
      fwd_bit_r <= ctl.wr_bit;
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      mem[s1_addr_r] <= ctl.wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      rdata_r <= mem[rd_ptr];
    end
  end

  // Slots not yet written since the last clear hold idle ticks
  assign old_bit = !s1_seen_r ? 1'b0 : (fwd_r ? fwd_bit_r : rdata_r);

endmodule

[hdl/window_load_hysteresis_governor_core.sv]
// Top level of the sliding-window load hysteresis governor.
`timescale 1ns / 1ps

// One item per tick: each accepted busy bit enters a window of the last
// window_ticks ticks and produces one result (mode, change pulse, busy count).
// The block takes one item every cycle unless a stalled result holds the
// update stage. The oldest busy bit is read from the ring memory as an item is
// accepted; the count, mode and memory write-back are done as it leaves the stage.
// Throughput is set by that single read and write per item on the ring memory,
// with forwarding when a one-tick window reads the slot just written. Reset and
// window rewrites need no clearing pass: a fill flag marks slots not written
// since, which count as idle. A window of zero disables the governor, and
// windows above WINDOW_MAX act as WINDOW_MAX. Configuration is taken while no
// item is in the update stage and should only be written when the block is idle.
module window_load_hysteresis_governor_core #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_busy_req,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_mode_fast,
  output logic                       out_mode_changed,
  output logic [whlg_pkg::CountW-1:0] out_busy_count,
  // configuration writes
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [whlg_pkg::CfgW-1:0]  cfg_data
);
  import whlg_pkg::*;

  localparam int PtrW = $clog2(WINDOW_MAX);
  localparam int EffW = PtrW + 1;

  // Configuration registers
  logic [CfgW-1:0]   window_r;
  logic [CfgW-1:0]   fast_thr_r;
  logic [CfgW-1:0]   slow_thr_r;
  logic              start_fast_r;

  // Governor state
  logic              mode_r, mode_nxt;
  logic [CountW-1:0] total_r, total_nxt;

  // Update stage
  logic              s1_v_r;
  logic              s1_busy_r;
  logic              s1_en_r;

  // Result register
  logic              out_valid_r;
  logic              out_mode_r;
  logic              out_changed_r;
  logic [CountW-1:0] out_count_r;

  logic              in_acc;
  logic              cfg_acc;
  logic              s1_adv;
  logic              out_free;
  logic              win_on;
  logic [EffW-1:0]   eff_win;
  logic              old_bit;
  logic              changed;
  whlg_ring_ctl_t    ring_ctl;

  // Window clamped to the ring depth
  assign eff_win = (32'(window_r) > 32'(WINDOW_MAX)) ? EffW'(WINDOW_MAX) : EffW'(window_r);
  assign win_on  = eff_win != '0;

  // Handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_v_r && out_free;
  assign in_stall  = s1_v_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = !s1_v_r;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // Ring control
  always_comb begin
    ring_ctl.issue  = in_acc && win_on;
    ring_ctl.commit = s1_adv && s1_en_r;
    ring_ctl.clear  = cfg_acc && (cfg_index == CFG_WINDOW);
    ring_ctl.wr_bit = s1_busy_r;
  end

  whlg_ring #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .eff_win (eff_win),
    .old_bit (old_bit)
  );

  // Running count and hysteresis decision
  always_comb begin
    total_nxt = total_r + CountW'(s1_busy_r) - CountW'(old_bit);
    mode_nxt  = mode_r;
    if (!mode_r) begin
      if (total_nxt >= fast_thr_r) begin
        mode_nxt = 1'b1;
      end
    end else begin
      if (total_nxt <= slow_thr_r) begin
        mode_nxt = 1'b0;
      end
    end
    changed = s1_en_r && (mode_nxt != mode_r);
  end

  // Control state, configuration and governor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= CfgW'(1024);
      fast_thr_r   <= CfgW'(768);
      slow_thr_r   <= CfgW'(256);
      start_fast_r <= 1'b0;
      mode_r       <= 1'b0;
      total_r      <= '0;
      s1_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv && s1_en_r) begin
        total_r <= total_nxt;
        mode_r  <= mode_nxt;
      end

      if (cfg_acc) begin
        case (cfg_index)
          CFG_WINDOW: begin
            window_r <= cfg_data;
            total_r  <= '0;
          end
          CFG_FAST_THR: begin
            fast_thr_r <= cfg_data;
          end
          CFG_SLOW_THR: begin
            slow_thr_r <= cfg_data;
          end
          CFG_START_FAST: begin
            start_fast_r <= cfg_data[0];
            mode_r       <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload of the update stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_busy_r <= in_busy_req;
      s1_en_r   <= win_on;
    end
  end

  // Result register; a disabled window reports the held state
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mode_r    <= s1_en_r ? mode_nxt : mode_r;
      out_changed_r <= changed;
      out_count_r   <= s1_en_r ? total_nxt : total_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mode_fast    = out_mode_r;
  assign out_mode_changed = out_changed_r;
  assign out_busy_count   = out_count_r;

  // Count never exceeds the window it covers
  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(eff_win) || !win_on)
    else $error("busy count exceeds window length");

  // Change pulse marks exactly a flip of the mode
  a_pulse_matches_flip: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_en_r |=> out_mode_changed == (out_mode_fast != $past(mode_r)))
    else $error("change pulse disagrees with mode transition");

  // A tick with the governor disabled leaves the count untouched and raises no change pulse
  a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_en_r |=> $stable(total_r) && !out_mode_changed)
    else $error("disabled tick altered governor state");

  // A start mode write loads the mode along with start_fast
  a_start_loads_mode: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc && cfg_index == CFG_START_FAST |=> mode_r == start_fast_r)
    else $error("start mode write did not load the mode");

endmodule
